// ===== sv/qsa_pkg.sv =====
// Shared widths and Q.30 constants for the approximate quaternion slerp pipeline.
// No dependencies.
package qsa_pkg;

   localparam int COMP_BITS_DEF = 16;
   localparam int FRAC          = 30;
   localparam int QW            = 31;   // component in Q.30
   localparam int T_IN_W        = 17;
   localparam int T_W           = 31;   // weight in Q.30
   localparam int WGT_W         = 33;   // blend weights a, b
   localparam int R_W           = 33;   // blended component
   localparam int N2_W          = 62;   // squared norm, Q.56
   localparam int ROOT_W        = 31;   // norm, Q.28
   localparam int SQRT_STEPS    = 31;

   localparam logic [T_IN_W-1:0] T_MAX = 17'd65536;
   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

   localparam logic [30:0] K_ACOS1 =
      31'((64'd698131701 * 64'd1073741824 + 64'd500000000) / 64'd1000000000);
   localparam logic [30:0] K_ACOS2 =
      31'((64'd872664626 * 64'd1073741824 + 64'd500000000) / 64'd1000000000);
   localparam logic [30:0] K_HALFPI =
      31'((64'd1570796327 * 64'd1073741824 + 64'd500000000) / 64'd1000000000);
   localparam logic [30:0] K_SIN1 =
      31'((64'd5643118 * 64'd1073741824 + 64'd500000000) / 64'd1000000000);
   localparam logic [30:0] K_SIN2 =
      31'((64'd155271411 * 64'd1073741824 + 64'd500000000) / 64'd1000000000);
   localparam logic [30:0] K_SIN3 =
      31'((64'd987862136 * 64'd1073741824 + 64'd500000000) / 64'd1000000000);
   localparam logic [30:0] K_THRESH =
      31'((64'd999000000 * 64'd1073741824 + 64'd500000000) / 64'd1000000000);

endpackage

// ===== sv/qsa_weight.sv =====
// Blend weight pipeline: dot product, shorter-arc sign, acos and sine polynomials; linear weights near alignment.
// Depends on qsa_pkg.
module qsa_weight
   import qsa_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic [8*QW-1:0]          in_q,
   input  logic [T_W-1:0]           in_t30,
   output logic                     out_valid,
   output logic signed [WGT_W-1:0]  out_a,
   output logic signed [WGT_W-1:0]  out_b,
   output logic [8*QW-1:0]          out_q
);

   localparam int NS = 11;

   logic [NS:1]        v_ff;
   logic [8*QW-1:0]    q_ff [1:NS];
   logic [T_W-1:0]     t_ff [1:NS-1];
   logic [NS-1:2]      neg_ff;
   logic [NS-1:3]      lin_ff;

   logic signed [2*QW-1:0] prod_ff [0:3];
   logic signed [2*QW-1:0] prod_in [0:3];
   logic signed [63:0]     dot_sum;
   logic signed [63:0]     dot_sh;
   logic signed [33:0]     dot_abs;
   logic [32:0]            dot_ff, dot_in;
   logic                   neg_in, lin_in;
   logic [61:0]            d2_p;
   logic [30:0]            d2_ff, d2_in, dot3_ff, dot4_ff;
   logic [61:0]            m1_p;
   logic signed [32:0]     s_w;
   logic signed [31:0]     s_ff, s_in;
   logic signed [63:0]     ang_p, ang_w;
   logic signed [31:0]     ang_ff, ang_in, ang6_ff;
   logic signed [63:0]     ta_p;
   logic signed [31:0]     ta_ff, ta_in;
   logic signed [31:0]     x7_ff [0:1], x7_in [0:1];
   logic signed [63:0]     x2_p [0:1];
   logic signed [32:0]     x2_ff [0:1], x2_in [0:1], x2_9_ff [0:1];
   logic signed [31:0]     x8_ff [0:1], x9_ff [0:1], x10_ff [0:1];
   logic signed [63:0]     p9_p [0:1], p9_w [0:1];
   logic signed [31:0]     p9_ff [0:1], p9_in [0:1];
   logic signed [63:0]     p10_p [0:1], p10_w [0:1];
   logic signed [31:0]     p10_ff [0:1], p10_in [0:1];
   logic signed [63:0]     y_p [0:1];
   logic signed [WGT_W-1:0] a_lin, a_sel, b_sel;
   logic signed [WGT_W-1:0] a_ff, a_in, b_ff, b_in;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         prod_in[i] = $signed(in_q[i*QW +: QW]) * $signed(in_q[(i+4)*QW +: QW]);
      end
      dot_sum = 64'(prod_ff[0]) + 64'(prod_ff[1]) + 64'(prod_ff[2]) + 64'(prod_ff[3]);
      dot_sh  = dot_sum >>> FRAC;
      neg_in  = dot_sum[63];
      dot_abs = neg_in ? -dot_sh[33:0] : dot_sh[33:0];
      dot_in  = dot_abs[32:0];

      lin_in = dot_ff >= 33'(K_THRESH);
      d2_p   = dot_ff[30:0] * dot_ff[30:0];
      d2_in  = d2_p[60:30];

      m1_p = K_ACOS1 * d2_ff;
      s_w  = -$signed({2'b00, m1_p[60:30]}) - $signed({2'b00, K_ACOS2});
      s_in = s_w[31:0];

      ang_p  = s_ff * $signed({1'b0, dot4_ff});
      ang_w  = (ang_p >>> FRAC) + $signed({33'd0, K_HALFPI});
      ang_in = ang_w[31:0];

      ta_p  = $signed({1'b0, t_ff[5]}) * ang_ff;
      ta_in = ta_p[FRAC+31:FRAC];

      x7_in[0] = ang6_ff - ta_ff;
      x7_in[1] = ta_ff;

      for (int l = 0; l < 2; l++) begin
         x2_p[l]   = x7_ff[l] * x7_ff[l];
         x2_in[l]  = x2_p[l][FRAC+32:FRAC];
         p9_p[l]   = $signed({1'b0, K_SIN1}) * x2_ff[l];
         p9_w[l]   = (p9_p[l] >>> FRAC) - $signed({33'd0, K_SIN2});
         p9_in[l]  = p9_w[l][31:0];
         p10_p[l]  = p9_ff[l] * x2_9_ff[l];
         p10_w[l]  = (p10_p[l] >>> FRAC) + $signed({33'd0, K_SIN3});
         p10_in[l] = p10_w[l][31:0];
         y_p[l]    = p10_ff[l] * x10_ff[l];
      end

      a_lin = $signed({2'b00, ONE_Q30}) - $signed({2'b00, t_ff[NS-1]});
      a_sel = lin_ff[NS-1] ? a_lin : y_p[0][FRAC+WGT_W-1:FRAC];
      b_sel = lin_ff[NS-1] ? $signed({2'b00, t_ff[NS-1]}) : y_p[1][FRAC+WGT_W-1:FRAC];
      a_in  = neg_ff[NS-1] ? -a_sel : a_sel;
      b_in  = b_sel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NS-1:1], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff[1] <= in_q;
         t_ff[1] <= in_t30;
         for (int k = 2; k <= NS; k++) q_ff[k] <= q_ff[k-1];
         for (int k = 2; k <= NS-1; k++) t_ff[k] <= t_ff[k-1];
         neg_ff <= {neg_ff[NS-2:2], neg_in};
         lin_ff <= {lin_ff[NS-2:3], lin_in};
         for (int i = 0; i < 4; i++) prod_ff[i] <= prod_in[i];
         dot_ff  <= dot_in;
         d2_ff   <= d2_in;
         dot3_ff <= dot_ff[30:0];
         s_ff    <= s_in;
         dot4_ff <= dot3_ff;
         ang_ff  <= ang_in;
         ta_ff   <= ta_in;
         ang6_ff <= ang_ff;
         for (int l = 0; l < 2; l++) begin
            x7_ff[l]   <= x7_in[l];
            x2_ff[l]   <= x2_in[l];
            x8_ff[l]   <= x7_ff[l];
            p9_ff[l]   <= p9_in[l];
            x2_9_ff[l] <= x2_ff[l];
            x9_ff[l]   <= x8_ff[l];
            p10_ff[l]  <= p10_in[l];
            x10_ff[l]  <= x9_ff[l];
         end
         a_ff <= a_in;
         b_ff <= b_in;
      end
   end

   assign out_valid = v_ff[NS];
   assign out_a     = a_ff;
   assign out_b     = b_ff;
   assign out_q     = q_ff[NS];

endmodule

// ===== sv/qsa_blend.sv =====
// Blend pipeline: weighted sum of the two quaternions and its squared norm.
// Depends on qsa_pkg.
module qsa_blend
   import qsa_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic signed [WGT_W-1:0]  in_a,
   input  logic signed [WGT_W-1:0]  in_b,
   input  logic [8*QW-1:0]          in_q,
   output logic                     out_valid,
   output logic [N2_W-1:0]          out_n2,
   output logic [4*R_W-1:0]         out_r
);

   localparam int NS = 4;

   logic [NS:1]            v_ff;
   logic signed [63:0]     pa_ff [0:3], pa_in [0:3];
   logic signed [63:0]     pb_ff [0:3], pb_in [0:3];
   logic signed [63:0]     rs_w [0:3];
   logic signed [R_W-1:0]  r_ff [0:3], r_in [0:3], r3_ff [0:3], r4_ff [0:3];
   logic signed [63:0]     sq_p [0:3];
   logic [58:0]            sq_ff [0:3], sq_in [0:3];
   logic [N2_W-1:0]        n2_ff, n2_in;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         pa_in[i] = in_a * $signed(in_q[i*QW +: QW]);
         pb_in[i] = in_b * $signed(in_q[(i+4)*QW +: QW]);
         rs_w[i]  = (pa_ff[i] + pb_ff[i]) >>> FRAC;
         r_in[i]  = rs_w[i][R_W-1:0];
         sq_p[i]  = r_ff[i] * r_ff[i];
         sq_in[i] = sq_p[i][62:4];
      end
      n2_in = N2_W'(sq_ff[0]) + N2_W'(sq_ff[1]) + N2_W'(sq_ff[2]) + N2_W'(sq_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NS-1:1], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            pa_ff[i] <= pa_in[i];
            pb_ff[i] <= pb_in[i];
            r_ff[i]  <= r_in[i];
            sq_ff[i] <= sq_in[i];
            r3_ff[i] <= r_ff[i];
            r4_ff[i] <= r3_ff[i];
         end
         n2_ff <= n2_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) out_r[i*R_W +: R_W] = r4_ff[i];
   end

   assign out_valid = v_ff[NS];
   assign out_n2    = n2_ff;

endmodule

// ===== sv/qsa_isqrt.sv =====
// Pipelined floor integer square root, two radicand bits per stage.
// Carries the blended components alongside. Depends on qsa_pkg.
module qsa_isqrt
   import qsa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [N2_W-1:0]      in_x,
   input  logic [4*R_W-1:0]     in_r,
   output logic                 out_valid,
   output logic [ROOT_W-1:0]    out_root,
   output logic [4*R_W-1:0]     out_r
);

   localparam int NS = SQRT_STEPS;
   localparam int RW = ROOT_W + 4;

   logic [NS:1]         v_ff;
   logic [N2_W-1:0]     x_ff [1:NS-1];
   logic [RW-1:0]       rem_ff [1:NS-1];
   logic [ROOT_W-1:0]   root_ff [1:NS];
   logic [4*R_W-1:0]    r_ff [1:NS];

   logic [N2_W-1:0]     x_s [0:NS-1];
   logic [RW-1:0]       rem_s [0:NS-1];
   logic [ROOT_W-1:0]   root_s [0:NS-1];
   logic [RW-1:0]       sh_w [0:NS-1], trial_w [0:NS-1];
   logic [NS-1:0]       ge_w;
   logic [N2_W-1:0]     x_n [1:NS];
   logic [RW-1:0]       rem_n [1:NS];
   logic [ROOT_W-1:0]   root_n [1:NS];

   always_comb begin
      x_s[0]    = in_x;
      rem_s[0]  = '0;
      root_s[0] = '0;
      for (int k = 1; k < NS; k++) begin
         x_s[k]    = x_ff[k];
         rem_s[k]  = rem_ff[k];
         root_s[k] = root_ff[k];
      end
      for (int k = 0; k < NS; k++) begin
         sh_w[k]      = {rem_s[k][RW-3:0], x_s[k][N2_W-1 -: 2]};
         trial_w[k]   = RW'({root_s[k], 2'b01});
         ge_w[k]      = sh_w[k] >= trial_w[k];
         rem_n[k+1]   = ge_w[k] ? sh_w[k] - trial_w[k] : sh_w[k];
         root_n[k+1]  = {root_s[k][ROOT_W-2:0], ge_w[k]};
         x_n[k+1]     = {x_s[k][N2_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NS-1:1], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[1] <= in_r;
         for (int k = 1; k <= NS; k++) root_ff[k] <= root_n[k];
         for (int k = 2; k <= NS; k++) r_ff[k] <= r_ff[k-1];
         for (int k = 1; k < NS; k++) begin
            x_ff[k]   <= x_n[k];
            rem_ff[k] <= rem_n[k];
         end
      end
   end

   assign out_valid = v_ff[NS];
   assign out_root  = root_ff[NS];
   assign out_r     = r_ff[NS];

endmodule

// ===== sv/qsa_div.sv =====
// Pipelined normalize: rounded restoring division of each component by four times
// the norm, one quotient bit per stage, then saturation into the output register.
// Depends on qsa_pkg.
module qsa_div
   import qsa_pkg::*;
#(
   parameter int CB = COMP_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [ROOT_W-1:0]    in_root,
   input  logic [4*R_W-1:0]     in_r,
   output logic                 out_valid,
   output logic [4*CB-1:0]      out_comp
);

   localparam int NS    = CB + 1;
   localparam int NW    = R_W + CB;
   localparam int RW    = ROOT_W + 4;
   localparam int DEN_W = ROOT_W + 2;

   logic [NS:0]          v_ff;
   logic                 out_v_ff;
   logic [RW-1:0]        rem_ff [0:NS-1][0:3];
   logic [CB:0]          lo_ff  [0:NS-1][0:3];
   logic [CB:0]          q_ff   [1:NS][0:3];
   logic [3:0]           neg_ff [0:NS];
   logic [DEN_W-1:0]     den_ff [0:NS-1];
   logic [NS:0]          zero_ff;
   logic [CB-1:0]        o_ff [0:3], o_in [0:3];

   logic [3:0]           neg0;
   logic [R_W-1:0]       mag0 [0:3];
   logic [NW-1:0]        n0 [0:3];
   logic [RW-1:0]        rem0 [0:3];
   logic [CB:0]          lo0 [0:3];
   logic [RW-1:0]        sh_w [1:NS][0:3];
   logic                 ge_w [1:NS][0:3];
   logic [RW-1:0]        rem_n [1:NS][0:3];
   logic [CB:0]          lo_n [1:NS][0:3];
   logic [CB:0]          q_s [0:NS-1][0:3];
   logic [CB:0]          q_n [1:NS][0:3];
   logic [CB:0]          qf [0:3];

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         neg0[l] = in_r[l*R_W + R_W-1];
         mag0[l] = neg0[l] ? -in_r[l*R_W +: R_W] : in_r[l*R_W +: R_W];
         n0[l]   = (NW'(mag0[l]) << (CB-1)) + NW'({in_root, 1'b0});
         rem0[l] = RW'(n0[l][NW-1:CB+1]);
         lo0[l]  = n0[l][CB:0];
         q_s[0][l] = '0;
      end
      for (int k = 1; k < NS; k++) begin
         for (int l = 0; l < 4; l++) q_s[k][l] = q_ff[k][l];
      end
      for (int k = 1; k <= NS; k++) begin
         for (int l = 0; l < 4; l++) begin
            sh_w[k][l]  = {rem_ff[k-1][l][RW-2:0], lo_ff[k-1][l][CB]};
            ge_w[k][l]  = sh_w[k][l] >= RW'(den_ff[k-1]);
            rem_n[k][l] = ge_w[k][l] ? sh_w[k][l] - RW'(den_ff[k-1]) : sh_w[k][l];
            lo_n[k][l]  = {lo_ff[k-1][l][CB-1:0], 1'b0};
            q_n[k][l]   = {q_s[k-1][l][CB-1:0], ge_w[k][l]};
         end
      end
      for (int l = 0; l < 4; l++) begin
         qf[l] = q_ff[NS][l];
         if (zero_ff[NS]) begin
            o_in[l] = '0;
         end else if (neg_ff[NS][l]) begin
            if (qf[l][CB] || (qf[l][CB-1] && (|qf[l][CB-2:0]))) begin
               o_in[l] = {1'b1, {(CB-1){1'b0}}};
            end else begin
               o_in[l] = ~qf[l][CB-1:0] + 1'b1;
            end
         end else if (qf[l][CB] || qf[l][CB-1]) begin
            o_in[l] = {1'b0, {(CB-1){1'b1}}};
         end else begin
            o_in[l] = qf[l][CB-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff     <= '0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         v_ff     <= {v_ff[NS-1:0], in_valid};
         out_v_ff <= v_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff[0]  <= neg0;
         den_ff[0]  <= {in_root, 2'b00};
         zero_ff[0] <= in_root == '0;
         for (int l = 0; l < 4; l++) begin
            rem_ff[0][l] <= rem0[l];
            lo_ff[0][l]  <= lo0[l];
            o_ff[l]      <= o_in[l];
         end
         for (int k = 1; k <= NS; k++) begin
            neg_ff[k]  <= neg_ff[k-1];
            zero_ff[k] <= zero_ff[k-1];
            for (int l = 0; l < 4; l++) q_ff[k][l] <= q_n[k][l];
         end
         for (int k = 1; k < NS; k++) begin
            den_ff[k] <= den_ff[k-1];
            for (int l = 0; l < 4; l++) begin
               rem_ff[k][l] <= rem_n[k][l];
               lo_ff[k][l]  <= lo_n[k][l];
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 4; l++) out_comp[l*CB +: CB] = o_ff[l];
   end

   assign out_valid = out_v_ff;

endmodule

// ===== sv/quaternion_slerp_approx.sv =====
// Approximate quaternion slerp, fully pipelined.
// Uses qsa_pkg, qsa_weight, qsa_blend, qsa_isqrt, qsa_div.
//
// Usage:
//   req_* carries one item: start quaternion qa, end quaternion qb (signed
//   Q1.(COMP_BITS-1)) and weight t (Q1.16, values above 1.0 clamp to 1.0).
//   rsp_* returns the normalized, saturated blend, one result per item, in order.
//   Both channels are valid/ready; an item moves when valid and ready are high.
// Throughput: one item per cycle while the output is not stalled.
// Stages: the weight polynomials (11), blend (4), a 31-stage square root and a
//   one-bit-per-stage divider of COMP_BITS + 1 stages plus load and output stages.
// Stall: while rsp_valid is high and rsp_ready low the whole pipeline holds and
//   req_ready drops; nothing is lost or repeated. Bubbles move on when the output
//   register is empty.
// Reset: synchronous; clears all valid bits, the pipeline comes up empty.
module quaternion_slerp_approx
   import qsa_pkg::*;
#(
   parameter int COMP_BITS = COMP_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COMP_BITS-1:0]  req_qa_w,
   input  logic signed [COMP_BITS-1:0]  req_qa_x,
   input  logic signed [COMP_BITS-1:0]  req_qa_y,
   input  logic signed [COMP_BITS-1:0]  req_qa_z,
   input  logic signed [COMP_BITS-1:0]  req_qb_w,
   input  logic signed [COMP_BITS-1:0]  req_qb_x,
   input  logic signed [COMP_BITS-1:0]  req_qb_y,
   input  logic signed [COMP_BITS-1:0]  req_qb_z,
   input  logic [T_IN_W-1:0]            req_t_weight,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COMP_BITS-1:0]  rsp_out_w,
   output logic signed [COMP_BITS-1:0]  rsp_out_x,
   output logic signed [COMP_BITS-1:0]  rsp_out_y,
   output logic signed [COMP_BITS-1:0]  rsp_out_z
);

   logic                   en;
   logic [COMP_BITS-1:0]   raw [0:7];
   logic [8*QW-1:0]        q_in;
   logic [T_IN_W-1:0]      t_clamp;
   logic [T_W-1:0]         t30;

   logic                   w_valid;
   logic signed [WGT_W-1:0] w_a, w_b;
   logic [8*QW-1:0]        w_q;
   logic                   b_valid;
   logic [N2_W-1:0]        b_n2;
   logic [4*R_W-1:0]       b_r;
   logic                   s_valid;
   logic [ROOT_W-1:0]      s_root;
   logic [4*R_W-1:0]       s_r;
   logic [4*COMP_BITS-1:0] comp;

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   assign raw[0] = req_qa_w;
   assign raw[1] = req_qa_x;
   assign raw[2] = req_qa_y;
   assign raw[3] = req_qa_z;
   assign raw[4] = req_qb_w;
   assign raw[5] = req_qb_x;
   assign raw[6] = req_qb_y;
   assign raw[7] = req_qb_z;

   for (genvar g = 0; g < 8; g++) begin : g_cvt
      if (COMP_BITS > QW) begin : g_shr
         assign q_in[g*QW +: QW] = raw[g][COMP_BITS-1:COMP_BITS-QW];
      end else if (COMP_BITS == QW) begin : g_same
         assign q_in[g*QW +: QW] = raw[g];
      end else begin : g_shl
         assign q_in[g*QW +: QW] = {raw[g], {(QW-COMP_BITS){1'b0}}};
      end
   end

   assign t_clamp = (req_t_weight > T_MAX) ? T_MAX : req_t_weight;
   assign t30     = {t_clamp, 14'd0};

   qsa_weight u_weight (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_q      (q_in),
      .in_t30    (t30),
      .out_valid (w_valid),
      .out_a     (w_a),
      .out_b     (w_b),
      .out_q     (w_q)
   );

   qsa_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (w_valid),
      .in_a      (w_a),
      .in_b      (w_b),
      .in_q      (w_q),
      .out_valid (b_valid),
      .out_n2    (b_n2),
      .out_r     (b_r)
   );

   qsa_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (b_valid),
      .in_x      (b_n2),
      .in_r      (b_r),
      .out_valid (s_valid),
      .out_root  (s_root),
      .out_r     (s_r)
   );

   qsa_div #(
      .CB (COMP_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s_valid),
      .in_root   (s_root),
      .in_r      (s_r),
      .out_valid (rsp_valid),
      .out_comp  (comp)
   );

   assign rsp_out_w = comp[0*COMP_BITS +: COMP_BITS];
   assign rsp_out_x = comp[1*COMP_BITS +: COMP_BITS];
   assign rsp_out_y = comp[2*COMP_BITS +: COMP_BITS];
   assign rsp_out_z = comp[3*COMP_BITS +: COMP_BITS];

`ifndef SYNTH
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output valid after reset");
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output register");
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input accepted while output stalled");
`endif

endmodule

// ===== bench/quaternion_slerp_approx_chk.sv =====
// Checker for quaternion_slerp_approx: watches both channels, predicts each result
// from the accepted item in Q.30 fixed point and compares field by field.
// Depends on qsa_pkg.
module quaternion_slerp_approx_chk
   import qsa_pkg::*;
#(
   parameter int COMP_BITS = COMP_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic signed [COMP_BITS-1:0]  req_qa_w,
   input  logic signed [COMP_BITS-1:0]  req_qa_x,
   input  logic signed [COMP_BITS-1:0]  req_qa_y,
   input  logic signed [COMP_BITS-1:0]  req_qa_z,
   input  logic signed [COMP_BITS-1:0]  req_qb_w,
   input  logic signed [COMP_BITS-1:0]  req_qb_x,
   input  logic signed [COMP_BITS-1:0]  req_qb_y,
   input  logic signed [COMP_BITS-1:0]  req_qb_z,
   input  logic [T_IN_W-1:0]            req_t_weight,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic signed [COMP_BITS-1:0]  rsp_out_w,
   input  logic signed [COMP_BITS-1:0]  rsp_out_x,
   input  logic signed [COMP_BITS-1:0]  rsp_out_y,
   input  logic signed [COMP_BITS-1:0]  rsp_out_z,
   output int                           fail_count,
   output int                           pending,
   output int                           rsp_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [COMP_BITS-1:0] comp_type;
   typedef struct packed {
      comp_type w, x, y, z;
   } quat_type;

   quat_type expected_q[$];
   longint n_linear, n_arc, n_flip;

   function automatic longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint qmul(longint a, longint b);
      return (a * b) >>> FRAC;
   endfunction

   function automatic longint sine_q30(longint x);
      longint x2, p;
      x2 = qmul(x, x);
      p = qmul(longint'(K_SIN1), x2) - longint'(K_SIN2);
      p = qmul(p, x2) + longint'(K_SIN3);
      return qmul(p, x);
   endfunction

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint to_q30(comp_type c);
      longint v;
      v = longint'(c);
      if (COMP_BITS <= 31) return v <<< (31 - COMP_BITS);
      return v >>> (COMP_BITS - 31);
   endfunction

   function automatic quat_type slerp_predict(quat_type qa, quat_type qb,
                                              logic [T_IN_W-1:0] tw);
      longint a_q[4], b_q[4], r[4];
      longint dot, t30, wa, wb, d2, s, ang, ta, num, o, maxv;
      longint unsigned n2, norm, den, mag, q;
      logic neg;
      comp_type res[4];
      quat_type out;
      a_q[0] = to_q30(qa.w); a_q[1] = to_q30(qa.x);
      a_q[2] = to_q30(qa.y); a_q[3] = to_q30(qa.z);
      b_q[0] = to_q30(qb.w); b_q[1] = to_q30(qb.x);
      b_q[2] = to_q30(qb.y); b_q[3] = to_q30(qb.z);
      dot = 0;
      for (int i = 0; i < 4; i++) dot += a_q[i] * b_q[i];
      dot = dot >>> FRAC;
      neg = dot < 0;
      if (neg) dot = -dot;
      if (tw > T_MAX) tw = T_MAX;
      t30 = longint'(tw) << 14;
      if (dot < longint'(K_THRESH)) begin
         d2 = qmul(dot, dot);
         s = -qmul(longint'(K_ACOS1), d2) - longint'(K_ACOS2);
         ang = qmul(s, dot) + longint'(K_HALFPI);
         ta = qmul(t30, ang);
         wb = sine_q30(ta);
         wa = sine_q30(ang - ta);
         n_arc++;
      end else begin
         wa = longint'(ONE_Q30) - t30;
         wb = t30;
         n_linear++;
      end
      if (neg) begin
         wa = -wa;
         n_flip++;
      end
      n2 = 0;
      for (int i = 0; i < 4; i++) begin
         r[i] = (wa * a_q[i] + wb * b_q[i]) >>> FRAC;
         n2 += longint'(r[i] * r[i]) >> 4;
      end
      norm = root_floor(n2);
      maxv = (longint'(1) << (COMP_BITS - 1)) - 1;
      for (int i = 0; i < 4; i++) begin
         o = 0;
         if (norm != 0) begin
            den = norm << 2;
            num = r[i] * (longint'(1) << (COMP_BITS - 1));
            mag = num < 0 ? -num : num;
            q = (mag + den / 2) / den;
            if (num < 0) o = (q > maxv + 1) ? -maxv - 1 : -longint'(q);
            else o = (q > maxv) ? maxv : longint'(q);
         end
         res[i] = comp_type'(o);
      end
      out.w = res[0]; out.x = res[1]; out.y = res[2]; out.z = res[3];
      return out;
   endfunction

   task automatic report_mismatch(string field, comp_type got, comp_type want);
      $display("ERROR result %0d field %s: got %0d expected %0d", rsp_count, field, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      quat_type qa, qb, e;
      if (reset) begin
         expected_q.delete();
         fail_count <= 0;
         rsp_count <= 0;
         pending <= 0;
      end else begin
         if (req_valid && req_ready) begin
            qa = {req_qa_w, req_qa_x, req_qa_y, req_qa_z};
            qb = {req_qb_w, req_qb_x, req_qb_y, req_qb_z};
            expected_q.push_back(slerp_predict(qa, qb, req_t_weight));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $display("ERROR result with no item pending");
               fail_count++;
            end else begin
               e = expected_q.pop_front();
               if (rsp_out_w !== e.w) report_mismatch("w", rsp_out_w, e.w);
               if (rsp_out_x !== e.x) report_mismatch("x", rsp_out_x, e.x);
               if (rsp_out_y !== e.y) report_mismatch("y", rsp_out_y, e.y);
               if (rsp_out_z !== e.z) report_mismatch("z", rsp_out_z, e.z);
            end
            rsp_count <= rsp_count + 1;
         end
         pending <= expected_q.size();
      end
   end

endmodule

// ===== bench/quaternion_slerp_approx_tb.sv =====
// Testbench top for quaternion_slerp_approx: directed and random quaternion pairs
// under several idle/stall mixes; checking in quaternion_slerp_approx_chk.
// Depends on qsa_pkg, the block and the checker.
module quaternion_slerp_approx_tb;
   import qsa_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB = COMP_BITS_DEF;
   localparam int LATENCY = 49 + CB;
   localparam int WATCHDOG = 20000;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_ready, rsp_valid, rsp_ready = 0;
   logic signed [CB-1:0] qa_w = 0, qa_x = 0, qa_y = 0, qa_z = 0;
   logic signed [CB-1:0] qb_w = 0, qb_x = 0, qb_y = 0, qb_z = 0;
   logic [T_IN_W-1:0] t_weight = 0;
   logic signed [CB-1:0] out_w, out_x, out_y, out_z;
   int fail_count, pending, rsp_count;
   int send_idle_pct = 0, recv_stall_pct = 0;
   int hold_cycles = 0;
   int idle_cycles = 0;
   int n_items = 0;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   quaternion_slerp_approx dut (
      .clock, .reset, .req_valid, .req_ready,
      .req_qa_w(qa_w), .req_qa_x(qa_x), .req_qa_y(qa_y), .req_qa_z(qa_z),
      .req_qb_w(qb_w), .req_qb_x(qb_x), .req_qb_y(qb_y), .req_qb_z(qb_z),
      .req_t_weight(t_weight), .rsp_valid, .rsp_ready,
      .rsp_out_w(out_w), .rsp_out_x(out_x), .rsp_out_y(out_y), .rsp_out_z(out_z)
   );

   quaternion_slerp_approx_chk chk (
      .clock, .reset, .req_valid, .req_ready,
      .req_qa_w(qa_w), .req_qa_x(qa_x), .req_qa_y(qa_y), .req_qa_z(qa_z),
      .req_qb_w(qb_w), .req_qb_x(qb_x), .req_qb_y(qb_y), .req_qb_z(qb_z),
      .req_t_weight(t_weight), .rsp_valid, .rsp_ready,
      .rsp_out_w(out_w), .rsp_out_x(out_x), .rsp_out_y(out_y), .rsp_out_z(out_z),
      .fail_count, .pending, .rsp_count
   );

   // receiver: random stalls plus an optional long hold-off
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("timeout: no handshake in %0d cycles", WATCHDOG);
         $display("quaternion_slerp_approx: mismatch");
         $finish;
      end
   end

   function automatic logic signed [CB-1:0] rand_comp();
      case ($urandom_range(7))
         0: return CB'(-(2 ** (CB - 1)));
         1: return CB'(2 ** (CB - 1) - 1);
         2: return '0;
         default: return CB'($urandom);
      endcase
   endfunction

   function automatic logic [T_IN_W-1:0] rand_t();
      case ($urandom_range(9))
         0: return '0;
         1: return T_MAX;
         2: return T_IN_W'(T_MAX + $urandom_range(65535, 1));
         default: return T_IN_W'($urandom_range(65536));
      endcase
   endfunction

   // one item; payload is set at the falling edge, valid held until accepted
   task automatic send(input logic signed [CB-1:0] aw, ax, ay, az, bw, bx, by, bz,
                       input logic [T_IN_W-1:0] tw);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      qa_w <= aw; qa_x <= ax; qa_y <= ay; qa_z <= az;
      qb_w <= bw; qb_x <= bx; qb_y <= by; qb_z <= bz;
      t_weight <= tw;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      n_items++;
   endtask

   // quaternion with random components, plus a partner near it, near its negation, or random
   task automatic send_pair();
      int a[4], b[4];
      int s;
      for (int i = 0; i < 4; i++) a[i] = $urandom_range(32767) - 16384;
      s = $urandom_range(3);
      for (int i = 0; i < 4; i++) begin
         if (s == 0) b[i] = a[i] + $urandom_range(8) - 4;
         else if (s == 1) b[i] = -a[i] + $urandom_range(8) - 4;
         else b[i] = $urandom_range(32767) - 16384;
      end
      send(CB'(a[0]), CB'(a[1]), CB'(a[2]), CB'(a[3]),
           CB'(b[0]), CB'(b[1]), CB'(b[2]), CB'(b[3]), rand_t());
   endtask

   task automatic drain();
      req_valid <= 0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   localparam logic signed [CB-1:0] PMAX = CB'(2 ** (CB - 1) - 1);
   localparam logic signed [CB-1:0] NMAX = CB'(-(2 ** (CB - 1)));
   localparam logic signed [CB-1:0] HALF = CB'(2 ** (CB - 2));

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: identity, opposite, orthogonal, extremes, zero blend, t clamp
      send(PMAX, 0, 0, 0, PMAX, 0, 0, 0, 0);
      send(PMAX, 0, 0, 0, PMAX, 0, 0, 0, T_MAX);
      send(PMAX, 0, 0, 0, NMAX, 0, 0, 0, 17'd32768);
      send(PMAX, 0, 0, 0, 0, PMAX, 0, 0, 17'd32768);
      send(PMAX, 0, 0, 0, 0, PMAX, 0, 0, 17'h1FFFF);
      send(HALF, HALF, HALF, HALF, HALF, -HALF, HALF, -HALF, 17'd16384);
      send(HALF, HALF, HALF, HALF, -HALF, -HALF, -HALF, -HALF, 17'd49152);
      send(0, 0, 0, 0, 0, 0, 0, 0, 17'd12345);
      send(PMAX, 0, 0, 0, -PMAX, 0, 0, 0, 17'd32768);
      send(NMAX, NMAX, NMAX, NMAX, NMAX, NMAX, NMAX, NMAX, 17'd1);
      send(PMAX, PMAX, PMAX, PMAX, NMAX, NMAX, NMAX, NMAX, 17'd65535);
      send(NMAX, PMAX, NMAX, PMAX, PMAX, NMAX, PMAX, NMAX, 17'd65537);
      send(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA,
           16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 17'h15555);
      send(0, 0, 0, PMAX, 0, 0, PMAX - 20, 1000, 17'h0AAAA);
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = (p == 1 || p == 3) ? (p == 1 ? 66 : 34) : 0;
         recv_stall_pct = (p == 2 || p == 3) ? (p == 2 ? 66 : 34) : 0;
         for (int i = 0; i < 400; i++) begin
            if (i == 100 && p == 0) hold_cycles <= 3 * LATENCY;
            if ($urandom_range(4) == 0)
               send(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                    rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_t());
            else
               send_pair();
         end
         drain();
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
      for (int i = 0; i < 100; i++) send_pair();
      drain();
      repeat (LATENCY + 10) @(negedge clock);
      $display("covered %0d items (%0d results): directed corner cases, near/opposite/random",
               n_items, rsp_count);
      $display("pairs, t clamp, and four idle/stall mixes with a long output hold-off");
      if (fail_count == 0 && pending == 0) begin
         $display("quaternion_slerp_approx: match");
      end else begin
         $display("quaternion_slerp_approx: mismatch");
      end
      $finish;
   end

endmodule

// ===== quaternion_slerp_approx.f =====
sv/qsa_pkg.sv
sv/qsa_weight.sv
sv/qsa_blend.sv
sv/qsa_isqrt.sv
sv/qsa_div.sv
sv/quaternion_slerp_approx.sv
bench/quaternion_slerp_approx_chk.sv
bench/quaternion_slerp_approx_tb.sv
